// ===== rtl/irpd_pkg.sv =====
// Shared types and constants for the pulse-distance IR frame decoder.
// Used by the classifier, the queue, the frame sequencer and the top level.
`default_nettype none

package irpd_pkg;

    // One mark/space pair from the capture side.
    typedef struct packed {
        logic [15:0] mark_us;
        logic [15:0] space_us;
        logic        frame_start;
        logic        last_pair;
    } t_in_item;

    // One decision on a frame.
    typedef struct packed {
        logic        accepted;
        logic [31:0] code;
        logic [5:0]  bit_count;
    } t_out_item;

    // Pair after timing classification, as it travels through the queue.
    typedef struct packed {
        logic frame_start;
        logic last_pair;
        logic hdr_ok;
        logic one_ok;
        logic zero_ok;
    } t_cls;

    localparam int unsigned CLS_W = $bits(t_cls);

    // Nominal durations, by index into the bound tables.
    localparam int unsigned NOM_COUNT = 5;
    localparam int unsigned NOM_W     = 3;
    localparam logic [NOM_W-1:0] NOM_HDR_MARK   = 3'd0;  // 8000 us
    localparam logic [NOM_W-1:0] NOM_HDR_SPACE  = 3'd1;  // 4000 us
    localparam logic [NOM_W-1:0] NOM_BIT_MARK   = 3'd2;  // 600 us
    localparam logic [NOM_W-1:0] NOM_ONE_SPACE  = 3'd3;  // 1600 us
    localparam logic [NOM_W-1:0] NOM_ZERO_SPACE = 3'd4;  // 550 us

    localparam logic [6:0] TOL_RESET = 7'd25;
    localparam logic [6:0] TOL_MAX   = 7'd100;
    localparam logic [7:0] PCT_BASE  = 8'd100;

    localparam logic [5:0] SHORT_FRAME_BITS = 6'd28;
    localparam logic [5:0] FULL_FRAME_BITS  = 6'd32;

    // floor(nominal * pct / 100). Every nominal but 550 is a multiple of 100,
    // and 550/100 is 11/2, so the bound is a small constant product.
    function automatic logic [15:0] scale_bound(input logic [NOM_W-1:0] nom,
                                                input logic [7:0] pct);
        logic [15:0] p;
        logic [15:0] r;
        p = 16'(pct);
        unique case (nom)
            NOM_HDR_MARK:   r = p * 16'd80;
            NOM_HDR_SPACE:  r = p * 16'd40;
            NOM_BIT_MARK:   r = p * 16'd6;
            NOM_ONE_SPACE:  r = p * 16'd16;
            NOM_ZERO_SPACE: r = (p * 16'd11) >> 1;
            default:        r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ir_pulse_distance_frame_decoder.sv =====
// Pulse-distance IR frame decoder: one mark/space pair per cycle while the queue is not full.
// Each pair passes through the queue, and each frame decision is loaded into a registered output.
// The queue between classifier and sequencer holds QUEUE_DEPTH pairs so each
// side stalls on its own.
// Reset (synchronous, i_rst_n low): idle, queue empty, tolerance back to 25 percent.
`default_nettype none

module ir_pulse_distance_frame_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire irpd_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output irpd_pkg::t_out_item     o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [6:0]         i_cfg_wdata
);
    import irpd_pkg::*;

    t_cls cls_in;
    t_cls cls_head;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;

    irpd_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_in_data),
        .o_cls       (cls_in)
    );

    assign o_in_stall = q_full;
    assign q_push     = i_in_valid && !q_full;

    irpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (cls_in),
        .i_pop   (q_pop),
        .o_data  (cls_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    irpd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cls       (cls_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/irpd_classify.sv =====
// Front part: holds the duration windows set by tolerance writes and flags
// each pair against the header, one and zero windows. Depends on irpd_pkg.
`default_nettype none

module irpd_classify (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [6:0]        i_cfg_wdata,
    input  wire irpd_pkg::t_in_item i_item,
    output irpd_pkg::t_cls          o_cls
);
    import irpd_pkg::*;

    logic [15:0] r_lo [NOM_COUNT];
    logic [15:0] r_hi [NOM_COUNT];
    logic [15:0] n_lo [NOM_COUNT];
    logic [15:0] n_hi [NOM_COUNT];

    logic [6:0] tol_sel;
    logic [6:0] tol_clamped;
    logic [7:0] pct_dn;
    logic [7:0] pct_up;

    // Tolerance above 100 acts as 100.
    always_comb begin
        tol_sel     = i_rst_n ? i_cfg_wdata : TOL_RESET;
        tol_clamped = (tol_sel > TOL_MAX) ? TOL_MAX : tol_sel;
        pct_dn      = PCT_BASE - {1'b0, tol_clamped};
        pct_up      = PCT_BASE + {1'b0, tol_clamped};
        for (int k = 0; k < NOM_COUNT; k++) begin
            n_lo[k] = scale_bound(NOM_W'(k), pct_dn);
            n_hi[k] = scale_bound(NOM_W'(k), pct_up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int k = 0; k < NOM_COUNT; k++) begin
                r_lo[k] <= n_lo[k];
                r_hi[k] <= n_hi[k];
            end
        end
    end

    logic hdr_mark_ok, hdr_space_ok, bit_mark_ok, one_space_ok, zero_space_ok;

    always_comb begin
        hdr_mark_ok   = (i_item.mark_us  >= r_lo[NOM_HDR_MARK])
                     && (i_item.mark_us  <= r_hi[NOM_HDR_MARK]);
        hdr_space_ok  = (i_item.space_us >= r_lo[NOM_HDR_SPACE])
                     && (i_item.space_us <= r_hi[NOM_HDR_SPACE]);
        bit_mark_ok   = (i_item.mark_us  >= r_lo[NOM_BIT_MARK])
                     && (i_item.mark_us  <= r_hi[NOM_BIT_MARK]);
        one_space_ok  = (i_item.space_us >= r_lo[NOM_ONE_SPACE])
                     && (i_item.space_us <= r_hi[NOM_ONE_SPACE]);
        zero_space_ok = (i_item.space_us >= r_lo[NOM_ZERO_SPACE])
                     && (i_item.space_us <= r_hi[NOM_ZERO_SPACE]);

        o_cls.frame_start = i_item.frame_start;
        o_cls.last_pair   = i_item.last_pair;
        o_cls.hdr_ok      = hdr_mark_ok && hdr_space_ok;
        o_cls.one_ok      = bit_mark_ok && one_space_ok;
        o_cls.zero_ok     = bit_mark_ok && zero_space_ok;
    end

endmodule

`default_nettype wire

// ===== rtl/irpd_fifo.sv =====
// Short queue of classified pairs between the classifier and the sequencer.
// Register-based, one push and one pop a cycle. Depends on irpd_pkg.
`default_nettype none

module irpd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire irpd_pkg::t_cls i_data,
    input  wire logic          i_pop,
    output irpd_pkg::t_cls      o_data,
    output logic               o_full,
    output logic               o_empty
);
    import irpd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/irpd_frame.sv =====
// Back part: frame sequencer. Pops classified pairs, collects bits and
// loads each decision into the output register. Depends on irpd_pkg.
`default_nettype none

module irpd_frame (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire irpd_pkg::t_cls i_cls,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output irpd_pkg::t_out_item o_out_data
);
    import irpd_pkg::*;

    localparam logic [0:0] PH_IDLE = 1'b0;
    localparam logic [0:0] PH_BITS = 1'b1;

    logic [0:0]  r_phase, n_phase;
    logic [5:0]  r_bits, n_bits;
    logic [31:0] r_shift, n_shift;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        out_free;
    logic        emit;
    logic        ok;
    logic [31:0] res_code;
    logic [5:0]  res_bits;
    logic [31:0] shifted;
    logic [5:0]  bits_inc;
    t_out_item   result;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = !i_empty && out_free;

    always_comb begin
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_shift  = r_shift;
        emit     = 1'b0;
        ok       = 1'b0;
        res_code = r_shift;
        res_bits = r_bits;
        shifted  = {r_shift[30:0], i_cls.one_ok};
        bits_inc = r_bits + 6'd1;

        if (o_pop) begin
            if (i_cls.frame_start) begin
                // Drop any running frame; this pair is the header.
                n_bits  = '0;
                n_shift = '0;
                if (!i_cls.hdr_ok || i_cls.last_pair) begin
                    emit    = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_BITS;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: n_phase = PH_IDLE;
                    PH_BITS: begin
                        if (i_cls.one_ok || i_cls.zero_ok) begin
                            n_shift  = shifted;
                            n_bits   = bits_inc;
                            res_code = shifted;
                            res_bits = bits_inc;
                            if (bits_inc >= FULL_FRAME_BITS) begin
                                emit = 1'b1;
                                ok   = 1'b1;
                            end else if (i_cls.last_pair) begin
                                emit = 1'b1;
                                ok   = (bits_inc == SHORT_FRAME_BITS);
                            end
                        end else begin
                            // Neither bit pattern: the frame ends here, accepted only at the short frame length.
                            emit = 1'b1;
                            ok   = (r_bits == SHORT_FRAME_BITS);
                        end
                        if (emit) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end

        result.accepted  = ok;
        result.code      = ok ? res_code : '0;
        result.bit_count = ok ? res_bits : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bits      <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            if (out_free) begin
                r_out_valid <= o_pop && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && o_pop && emit) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_bits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BITS |-> r_bits < FULL_FRAME_BITS)
        else $error("bit count reached full frame while collecting");

    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.accepted |->
            (r_out_data.bit_count == SHORT_FRAME_BITS
             || r_out_data.bit_count == FULL_FRAME_BITS))
        else $error("accepted frame with odd bit count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.accepted |->
            (r_out_data.code == '0 && r_out_data.bit_count == '0))
        else $error("rejection carries data");

endmodule

`default_nettype wire

// ===== tb/ir_frame_check_pkg.sv =====
// Scoreboard for the pulse-distance IR frame decoder testbench: a cycle-free
// frame predictor plus the queue of decisions it expects. Depends on irpd_pkg.
package ir_frame_check_pkg;

    import irpd_pkg::*;

    localparam int unsigned HDR_MARK_NOM   = 8000;
    localparam int unsigned HDR_SPACE_NOM  = 4000;
    localparam int unsigned BIT_MARK_NOM   = 600;
    localparam int unsigned ONE_SPACE_NOM  = 1600;
    localparam int unsigned ZERO_SPACE_NOM = 550;

    typedef enum logic {
        PH_IDLE,
        PH_COLLECT
    } t_frame_phase;

    // Inclusive window edge around a nominal duration; tolerance saturates at 100.
    function automatic int unsigned tol_bound(int unsigned nominal, logic [6:0] tol,
                                              bit upper);
        int unsigned t;
        t = (tol > TOL_MAX) ? int'(TOL_MAX) : int'(tol);
        return upper ? nominal * (PCT_BASE + t) / PCT_BASE
                     : nominal * (PCT_BASE - t) / PCT_BASE;
    endfunction

    class t_frame_scoreboard;
        logic [6:0]   tol;
        t_frame_phase phase;
        logic [5:0]   bits_seen;
        logic [31:0]  shift_word;
        t_out_item    pending [$];
        int unsigned  failures;
        int unsigned  decisions;

        function new();
            tol        = TOL_RESET;
            phase      = PH_IDLE;
            bits_seen  = '0;
            shift_word = '0;
            failures   = 0;
            decisions  = 0;
        endfunction

        function void set_tolerance(logic [6:0] v);
            tol = v;
        endfunction

        function bit in_window(logic [15:0] d, int unsigned nominal);
            return d >= tol_bound(nominal, tol, 1'b0) && d <= tol_bound(nominal, tol, 1'b1);
        endfunction

        function bit pair_is(t_in_item p, int unsigned nm, int unsigned ns);
            return in_window(p.mark_us, nm) && in_window(p.space_us, ns);
        endfunction

        function void decide(bit ok);
            t_out_item d;
            d.accepted  = ok;
            d.code      = ok ? shift_word : '0;
            d.bit_count = ok ? bits_seen : '0;
            pending.push_back(d);
            phase = PH_IDLE;
        endfunction

        // Advance the frame state by one transfer; returns 1 unless the pair is ignored.
        function bit note_pair(t_in_item p);
            bit took;
            took = p.frame_start || phase == PH_COLLECT;
            if (p.frame_start) begin
                bits_seen  = '0;
                shift_word = '0;
                if (!pair_is(p, HDR_MARK_NOM, HDR_SPACE_NOM) || p.last_pair)
                    decide(1'b0);
                else
                    phase = PH_COLLECT;
            end else if (phase == PH_COLLECT) begin
                // a pair inside both bit windows counts as a one
                if (pair_is(p, BIT_MARK_NOM, ONE_SPACE_NOM)) begin
                    shift_word = {shift_word[30:0], 1'b1};
                end else if (pair_is(p, BIT_MARK_NOM, ZERO_SPACE_NOM)) begin
                    shift_word = {shift_word[30:0], 1'b0};
                end else begin
                    decide(bits_seen == SHORT_FRAME_BITS);
                    return took;
                end
                bits_seen++;
                if (bits_seen >= FULL_FRAME_BITS)
                    decide(1'b1);
                else if (p.last_pair)
                    decide(bits_seen == SHORT_FRAME_BITS);
            end
            return took;
        endfunction

        function void check_decision(t_out_item got);
            t_out_item want;
            decisions++;
            if (pending.size() == 0) begin
                $error("decision with none expected: accepted %0d code %h bit_count %0d",
                       got.accepted, got.code, got.bit_count);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                failures++;
            end
            if (got.code !== want.code) begin
                $error("code: expected %h, got %h", want.code, got.code);
                failures++;
            end
            if (got.bit_count !== want.bit_count) begin
                $error("bit_count: expected %0d, got %0d", want.bit_count, got.bit_count);
                failures++;
            end
        endfunction
    endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench for ir_pulse_distance_frame_decoder: drives directed and
// random captures with random gaps and stalls, checks every decision.
// Depends on irpd_pkg and ir_frame_check_pkg.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import irpd_pkg::*;
    import ir_frame_check_pkg::*;

    localparam int unsigned ITEM_TARGET     = 1900;
    localparam int unsigned DECISION_TARGET = 60;
    localparam int unsigned PHASE_PAIRS     = 190;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned TIMEOUT_NS      = 10_000_000;
    localparam logic [6:0]  TOL_PLAN [0:5]  = '{7'd0, 7'd127, 7'd100, 7'd1, 7'd99, 7'd25};

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = '0;

    logic [6:0]  cur_tol     = TOL_RESET;
    logic        calm        = 1'b0;
    int unsigned stall_run   = 0;
    int unsigned pairs_used  = 0;
    int unsigned phase_pairs = 0;

    t_frame_scoreboard sb = new();

    ir_pulse_distance_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short idle runs, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Alternate stalled and free runs on the result side.
    always @(posedge i_clk) begin
        if (!rst_n || calm) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(0, 12);
        end else begin
            out_stall <= 1'b1;
            stall_run <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_decision(out_data);
    end

    function automatic t_in_item mk_pair(logic [15:0] m, logic [15:0] s, logic st, logic l);
        t_in_item p;
        p.mark_us     = m;
        p.space_us    = s;
        p.frame_start = st;
        p.last_pair   = l;
        return p;
    endfunction

    // Duration inside the current window, now and then on an edge or just outside it.
    function automatic logic [15:0] near_dur(int unsigned nominal);
        int unsigned lo;
        int unsigned hi;
        int unsigned r;
        int unsigned d;
        lo = tol_bound(nominal, cur_tol, 1'b0);
        hi = tol_bound(nominal, cur_tol, 1'b1);
        r  = $urandom_range(0, 99);
        if (r < 4)
            d = lo;
        else if (r < 8)
            d = hi;
        else if (r < 9)
            d = (lo == 0) ? hi + 1 : lo - 1;
        else if (r < 10)
            d = hi + 1;
        else
            d = $urandom_range(lo, hi);
        return (d > 65535) ? 16'hFFFF : 16'(d);
    endfunction

    function automatic t_in_item header_pair(logic l);
        return mk_pair(near_dur(HDR_MARK_NOM), near_dur(HDR_SPACE_NOM), 1'b1, l);
    endfunction

    function automatic t_in_item bit_pair(logic one, logic l);
        return mk_pair(near_dur(BIT_MARK_NOM),
                       near_dur(one ? ONE_SPACE_NOM : ZERO_SPACE_NOM), 1'b0, l);
    endfunction

    function automatic t_in_item noise_pair(logic st, logic l);
        logic [15:0] s;
        s = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
        return mk_pair(16'($urandom_range(0, 65535)), s, st, l);
    endfunction

    task automatic send_pair(input t_in_item p);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (!(in_valid && !in_stall));
        if (sb.note_pair(p)) begin
            pairs_used++;
            phase_pairs++;
        end
    endtask

    task automatic send_bits(input int unsigned n, input logic last_on_final);
        for (int unsigned k = 1; k <= n; k++)
            send_pair(bit_pair(1'($urandom_range(0, 1)), last_on_final && k == n));
    endtask

    // Drop valid and let every expected decision and queued pair work through.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tol(input logic [6:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_tolerance(v);
        cur_tol = v;
    endtask

    task automatic run_directed();
        t_in_item seq [$];
        seq = '{
            mk_pair(16'd65535, 16'd65535, 1'b0, 1'b0),
            mk_pair(16'd0,     16'd0,     1'b1, 1'b0),
            mk_pair(16'd8000,  16'd4000,  1'b1, 1'b1),
            mk_pair(16'd8000,  16'd4000,  1'b1, 1'b0),
            mk_pair(16'd600,   16'd1600,  1'b0, 1'b0),
            mk_pair(16'd600,   16'd550,   1'b0, 1'b0),
            mk_pair(16'd8000,  16'd4000,  1'b1, 1'b0),
            mk_pair(16'd600,   16'd1600,  1'b0, 1'b0),
            mk_pair(16'd65535, 16'd0,     1'b0, 1'b0),
            mk_pair(16'd10000, 16'd5000,  1'b1, 1'b0),
            mk_pair(16'd450,   16'd412,   1'b0, 1'b0),
            mk_pair(16'd750,   16'd2000,  1'b0, 1'b1),
            mk_pair(16'd6000,  16'd3000,  1'b1, 1'b0),
            mk_pair(16'd449,   16'd1600,  1'b0, 1'b0),
            mk_pair(16'd6000,  16'd2999,  1'b1, 1'b0),
            mk_pair(16'd10001, 16'd4000,  1'b1, 1'b0),
            mk_pair(16'd8000,  16'd4000,  1'b1, 1'b0),
            mk_pair(16'd751,   16'd550,   1'b0, 1'b0),
            mk_pair(16'd600,   16'd1600,  1'b0, 1'b0)
        };
        foreach (seq[k])
            send_pair(seq[k]);
    endtask

    // One capture, mostly well formed, sometimes cut short or broken.
    task automatic run_frame();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        if (kind < 90)
            send_pair(header_pair(1'b0));
        if (kind < 35) begin
            send_bits(32, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 2))
                send_pair(($urandom_range(0, 1) != 0)
                          ? bit_pair(1'($urandom_range(0, 1)), 1'b0)
                          : noise_pair(1'b0, 1'($urandom_range(0, 1))));
        end else if (kind < 60) begin
            send_bits(28, 1'b1);
        end else if (kind < 75) begin
            send_bits(28, 1'b0);
            send_pair(noise_pair(1'b0, 1'($urandom_range(0, 1))));
        end else if (kind < 85) begin
            n = $urandom_range(1, 31);
            if ($urandom_range(0, 1) != 0) begin
                send_bits(n, 1'b1);
            end else begin
                send_bits(n, 1'b0);
                send_pair(noise_pair(1'b0, 1'($urandom_range(0, 1))));
            end
        end else if (kind < 90) begin
            // leave the frame open; the next capture start drops it
            send_bits($urandom_range(1, 27), 1'b0);
        end else if (kind < 95) begin
            send_pair(header_pair(1'b1));
        end else begin
            send_pair(noise_pair(1'b1, 1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        int unsigned plan_idx;
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain();
        plan_idx = 0;
        while (pairs_used < ITEM_TARGET || sb.decisions < DECISION_TARGET) begin
            write_tol((plan_idx < 6) ? TOL_PLAN[plan_idx] : 7'($urandom_range(0, 127)));
            plan_idx++;
            calm <= ($urandom_range(0, 3) == 0);
            phase_pairs = 0;
            while (phase_pairs < PHASE_PAIRS)
                run_frame();
            drain();
        end
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
